@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the search-ROM checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is held.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// The same check, with no reset qualifier.
`define ASSERT_CLK_ALWAYS(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

@@ rtl/ors_pkg.sv @@
// ---------------------------------------------------------------------------
// ors_pkg
// Types, codes and the CRC-8/MAXIM helper for the 1-Wire search-ROM engine.
// ---------------------------------------------------------------------------
package ors_pkg;

	// Request opcodes (s_tuser)
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_BIT   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Result kinds (m_tuser)
	localparam logic KIND_DIR    = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam int ROM_W     = 64;
	localparam int POS_W     = 7;
	localparam int FAM_W     = 4;
	localparam int S_DATA_W  = 8;
	localparam int M_DATA_W  = 72;
	localparam int FIFO_AW   = 2;
	localparam int FIFO_CW   = FIFO_AW + 1;
	localparam int FIFO_D    = 1 << FIFO_AW;

	localparam logic [POS_W-1:0] POS_FIRST  = 7'd1;
	localparam logic [POS_W-1:0] POS_LAST   = 7'd64;
	localparam logic [POS_W-1:0] POS_FAMEND = 7'd9;
	localparam logic [7:0]       CRC_POLY   = 8'h8C;

	// Search state
	typedef struct packed {
		logic [ROM_W-1:0] rom;
		logic [POS_W-1:0] prior_disc;
		logic [FAM_W-1:0] fam_mark;
		logic             done_all;
		logic [POS_W-1:0] bit_pos;
		logic [POS_W-1:0] zero_pos;
		logic [7:0]       crc;
		logic             active;
	} state_t;

	// One result item
	typedef struct packed {
		logic             kind;
		logic             direction;
		logic             found;
		logic [ROM_W-1:0] rom_code;
		logic             last_device;
		logic [FAM_W-1:0] family_discrepancy;
		logic             last;
	} res_t;

	// Reflected CRC-8, x^8+x^5+x^4+1, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/ors_step.sv @@
// ---------------------------------------------------------------------------
// ors_step
// Next-state and result logic for one request of the search-ROM engine.
// ---------------------------------------------------------------------------
module ors_step import ors_pkg::*; (
	input  logic [1:0] op,
	input  logic       no_presence,
	input  logic       id_bit,
	input  logic       comp_bit,
	input  state_t     cur,
	output state_t     nxt,
	output logic [1:0] res_cnt,
	output res_t       res0,
	output res_t       res1
);

	always_comb begin
		state_t           s;
		logic [POS_W-1:0] bp;
		logic [5:0]       pos;
		logic [5:0]       byte_sh;
		logic [ROM_W-1:0] rom_sh;
		logic             dir;
		logic             ok;

		s       = cur;
		res_cnt = 2'd0;
		res0    = '0;
		res1    = '0;
		bp      = POS_FIRST;
		pos     = '0;
		byte_sh = '0;
		rom_sh  = '0;
		dir     = 1'b0;
		ok      = 1'b0;

		case (op)
			OP_BEGIN: begin
				s.bit_pos  = POS_FIRST;
				s.zero_pos = '0;
				s.crc      = '0;
				s.active   = 1'b0;
				if (cur.done_all || no_presence) begin
					s.prior_disc = '0;
					s.done_all   = 1'b0;
					s.fam_mark   = '0;
					res_cnt      = 2'd1;
					res0         = '{KIND_FINISH, 1'b0, 1'b0, s.rom, s.done_all,
						s.fam_mark, 1'b1};
				end else begin
					s.active = 1'b1;
				end
			end
			OP_CLEAR: begin
				s.prior_disc = '0;
				s.done_all   = 1'b0;
				s.fam_mark   = '0;
				s.active     = 1'b0;
			end
			OP_BIT: begin
				if (cur.active) begin
					if (id_bit && comp_bit) begin
						// no device answered: abort the pass
						s.active     = 1'b0;
						s.prior_disc = '0;
						s.done_all   = 1'b0;
						s.fam_mark   = '0;
						res_cnt      = 2'd1;
						res0         = '{KIND_FINISH, 1'b0, 1'b0, s.rom, s.done_all,
							s.fam_mark, 1'b1};
					end else begin
						// position 1..64, anything else folds to 1
						bp = cur.bit_pos;
						if (bp < POS_FIRST || bp > POS_LAST) begin
							bp = POS_FIRST;
						end
						pos = 6'(bp - POS_FIRST);

						// discrepancy rules
						if (id_bit != comp_bit) begin
							dir = id_bit;
						end else begin
							if (bp < cur.prior_disc) begin
								dir = cur.rom[pos];
							end else begin
								dir = (bp == cur.prior_disc);
							end
							if (!dir) begin
								s.zero_pos = bp;
								if (bp < POS_FAMEND) begin
									s.fam_mark = FAM_W'(bp);
								end
							end
						end
						s.rom[pos] = dir;

						// CRC over each completed byte
						if (bp[2:0] == 3'd0) begin
							byte_sh = 6'(bp - 7'd8);
							rom_sh  = s.rom >> byte_sh;
							s.crc   = crc8_byte(cur.crc, rom_sh[7:0]);
						end
						s.bit_pos = bp + POS_FIRST;

						res_cnt = 2'd1;
						res0    = '{KIND_DIR, dir, 1'b0, s.rom, s.done_all, s.fam_mark,
							(bp != POS_LAST)};

						// end of pass
						if (bp == POS_LAST) begin
							s.active = 1'b0;
							if (s.crc == 8'd0) begin
								s.prior_disc = s.zero_pos;
								if (s.zero_pos == '0) begin
									s.done_all = 1'b1;
								end
								ok = 1'b1;
							end
							if (!ok || s.rom[7:0] == 8'd0) begin
								s.prior_disc = '0;
								s.done_all   = 1'b0;
								s.fam_mark   = '0;
								ok           = 1'b0;
							end
							res_cnt = 2'd2;
							res1    = '{KIND_FINISH, 1'b0, ok, s.rom, s.done_all,
								s.fam_mark, 1'b1};
						end
					end
				end
			end
			default: begin
				// undefined opcode: no effect
			end
		endcase
		nxt = s;
	end

endmodule

@@ rtl/ors_res_fifo.sv @@
// ---------------------------------------------------------------------------
// ors_res_fifo
// Small result queue: up to two pushes and one pop per cycle.
// ---------------------------------------------------------------------------
module ors_res_fifo import ors_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         push_cnt,
	input  res_t               push0,
	input  res_t               push1,
	input  logic               pop,
	output logic               not_empty,
	output logic [FIFO_CW-1:0] count,
	output res_t               head
);

	res_t               mem_q [FIFO_D];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_pop;

	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_q];
	assign count     = cnt_q;

	// Storage, payload only
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_q + FIFO_AW'(1)] <= push1;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_AW'(push_cnt);
			rd_q  <= rd_q + FIFO_AW'(do_pop);
			cnt_q <= cnt_q + FIFO_CW'(push_cnt) - FIFO_CW'(do_pop);
		end
	end

endmodule

@@ rtl/onewire_rom_search_core.sv @@
// ---------------------------------------------------------------------------
// onewire_rom_search_core
// 1-Wire search-ROM engine, one bus bit pair per request.
// ---------------------------------------------------------------------------
// Takes one request per clock while s_tready is high. A request lands in an
// input register; while the queue has room, the step logic then updates the
// search state and writes its results (none, one or two) into a four-entry
// result queue, so a result passes the input register and the queue before
// it is offered on the master side.
// s_tready drops only while the input register holds a request and the
// queue has fewer than two free entries; with results drained as they come,
// the sustained rate is one request per cycle, and a completing pass pushes
// two results.
module onewire_rom_search_core import ors_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // no_presence, id_bit, comp_bit, zero pad
	input  logic [1:0]          s_tuser,  // op
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // direction, found, rom_code[63:0],
	                                      // last_device, family_discrepancy[3:0], pad
	output logic                m_tuser,  // kind
	output logic                m_tlast
);

	logic               in_valid_s1;
	logic [1:0]         op_s1;
	logic [2:0]         bits_s1;
	logic               adv;
	state_t             st_q;
	state_t             st_nxt;
	logic [1:0]         res_cnt;
	logic [1:0]         push_cnt;
	res_t               res0;
	res_t               res1;
	res_t               head;
	logic [FIFO_CW-1:0] fcount;

	// Step advances when the queue has room for two results
	assign adv      = in_valid_s1 && (fcount <= FIFO_CW'(FIFO_D - 2));
	assign s_tready = !in_valid_s1 || adv;
	assign push_cnt = adv ? res_cnt : 2'd0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			bits_s1 <= s_tdata[2:0];
		end
	end

	// Search state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{rom: '0, prior_disc: '0, fam_mark: '0, done_all: 1'b0,
				bit_pos: POS_FIRST, zero_pos: '0, crc: '0, active: 1'b0};
		end else if (adv) begin
			st_q <= st_nxt;
		end
	end

	ors_step u_step (
		.op          (op_s1),
		.no_presence (bits_s1[0]),
		.id_bit      (bits_s1[1]),
		.comp_bit    (bits_s1[2]),
		.cur         (st_q),
		.nxt         (st_nxt),
		.res_cnt     (res_cnt),
		.res0        (res0),
		.res1        (res1)
	);

	ors_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.push0     (res0),
		.push1     (res1),
		.pop       (m_tready),
		.not_empty (m_tvalid),
		.count     (fcount),
		.head      (head)
	);

	// Output packing
	assign m_tuser = head.kind;
	assign m_tlast = head.last;
	assign m_tdata = {1'b0, head.family_discrepancy, head.last_device, head.rom_code,
		head.found, head.direction};

endmodule

@@ rtl/ors_checker.sv @@
// ---------------------------------------------------------------------------
// ors_checker
// Port-level checks on the search-ROM engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ors_checker import ors_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata,
	input logic                m_tuser,
	input logic                m_tlast
);

	logic             out_fin;
	logic             out_dir;
	logic [FAM_W-1:0] out_fam;

	assign out_fin = m_tvalid && (m_tuser == KIND_FINISH);
	assign out_dir = m_tvalid && (m_tuser == KIND_DIR);
	assign out_fam = m_tdata[70:67];

	// A stalled result stays offered
	`ASSERT_CLK(a_hold_valid, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped")

	// A finish result always closes its request and carries no direction
	`ASSERT_CLK(a_finish_last, clk, arst_n, out_fin |-> m_tlast && !m_tdata[0], "bad finish")

	// Direction results never claim a found ROM
	`ASSERT_CLK(a_dir_nofound, clk, arst_n, out_dir |-> !m_tdata[1], "direction with found")

	// Family mark stays within the family byte
	`ASSERT_CLK(a_fam_range, clk, arst_n, m_tvalid |-> out_fam <= 4'd8, "family mark range")

endmodule

bind onewire_rom_search_core ors_checker u_ors_checker (.*);
